// ----- sv/rgbhsl_pkg.sv -----
// Shared widths and constants for the RGB to HSL converter.
package rgbhsl_pkg;

  // Channel, result and sum widths.
  localparam int CH_W  = 8;
  localparam int OUT_W = 16;
  localparam int SUM_W = CH_W + 1;

  // Full-scale channel value.
  localparam int CH_MAX = 255;

  // Long division: one quotient bit per pipeline stage.
  localparam int DIV_STEPS = OUT_W;
  // Divisor width covers six times the channel range.
  localparam int DVS_W = CH_W + 3;
  // Partial remainder keeps one spare bit for the shift before the compare.
  localparam int REM_W = DVS_W + 1;

  // Pipeline layout: classify, prepare, divide steps, output.
  localparam int ST_CLS  = 0;
  localparam int ST_PREP = 1;
  localparam int ST_DIV0 = 2;
  localparam int NUM_ST  = DIV_STEPS + 3;
  localparam int ST_OUT  = NUM_ST - 1;

endpackage

// ----- sv/rgbhsl_if.sv -----
// Handshake interfaces for the pixel input and the HSL result channels.
interface rgbhsl_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rgbhsl_pkg::CH_W-1:0] red;
  logic [rgbhsl_pkg::CH_W-1:0] green;
  logic [rgbhsl_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsl_hsl_if;
  logic                         valid;
  logic                         ready;
  logic [rgbhsl_pkg::OUT_W-1:0] hue;
  logic [rgbhsl_pkg::OUT_W-1:0] saturation;
  logic [rgbhsl_pkg::OUT_W-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

// ----- sv/rgbhsl_div.sv -----
// Pipelined restoring divider that produces one quotient bit per stage.
module rgbhsl_div (
  input  logic                                clk_i,
  input  logic [rgbhsl_pkg::DIV_STEPS-1:0]    en_i,
  input  logic [rgbhsl_pkg::REM_W-1:0]        rem_i,
  input  logic [rgbhsl_pkg::DVS_W-1:0]        dvs_i,
  input  logic [rgbhsl_pkg::DIV_STEPS-1:0]    dvd_i,
  output logic [rgbhsl_pkg::DIV_STEPS-1:0]    quo_o
);
  import rgbhsl_pkg::*;

  logic [REM_W-1:0]     rem_q [DIV_STEPS];
  logic [DVS_W-1:0]     dvs_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] dvd_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS];

  logic [REM_W-1:0]     src_rem [DIV_STEPS];
  logic [DVS_W-1:0]     src_dvs [DIV_STEPS];
  logic [DIV_STEPS-1:0] src_dvd [DIV_STEPS];
  logic [DIV_STEPS-1:0] src_quo [DIV_STEPS];
  logic [REM_W-1:0]     shf     [DIV_STEPS];
  logic                 geq     [DIV_STEPS];

  logic [REM_W-1:0]     rem_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] dvd_d [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_d [DIV_STEPS];

  // Each stage shifts in the next dividend bit and subtracts when it can.
  // The partial remainder stays below the divisor, so the shift never overflows.
  always_comb begin
    src_rem[0] = rem_i;
    src_dvs[0] = dvs_i;
    src_dvd[0] = dvd_i;
    src_quo[0] = '0;
    for (int k = 1; k < DIV_STEPS; k++) begin
      src_rem[k] = rem_q[k-1];
      src_dvs[k] = dvs_q[k-1];
      src_dvd[k] = dvd_q[k-1];
      src_quo[k] = quo_q[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      shf[k]   = {src_rem[k][REM_W-2:0], src_dvd[k][DIV_STEPS-1]};
      geq[k]   = (shf[k] >= {1'b0, src_dvs[k]});
      rem_d[k] = geq[k] ? (shf[k] - {1'b0, src_dvs[k]}) : shf[k];
      dvd_d[k] = {src_dvd[k][DIV_STEPS-2:0], 1'b0};
      quo_d[k] = {src_quo[k][DIV_STEPS-2:0], geq[k]};
    end
  end

  // Stage registers advance under their own enables.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d[k];
        dvs_q[k] <= src_dvs[k];
        dvd_q[k] <= dvd_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

// ----- sv/rgb_to_hsl_converter_core.sv -----
// RGB to HSL converter: 19-stage pipeline with two pipelined long dividers.
// Throughput: one pixel per cycle while hsl_o is not stalled; the 16 one-bit divide stages set the depth.
// Each stage holds its beat under backpressure and refills as soon as it empties.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data is not reset.
module rgb_to_hsl_converter_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  rgbhsl_pix_if.sink          pix_i,
  rgbhsl_hsl_if.source        hsl_o
);
  import rgbhsl_pkg::*;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  logic [NUM_ST-1:0] v_q;
  logic [NUM_ST-1:0] take;

  // Stage loads when empty or when its beat moves on; ready ripples back.
  always_comb begin
    take[ST_OUT] = !v_q[ST_OUT] || hsl_o.ready;
    for (int k = ST_OUT - 1; k >= 0; k--) begin
      take[k] = !v_q[k] || take[k+1];
    end
  end

  assign pix_i.ready = take[ST_CLS];

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (take[ST_CLS]) begin
        v_q[ST_CLS] <= pix_i.valid;
      end
      for (int k = 1; k < NUM_ST; k++) begin
        if (take[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Classify: find the largest and smallest channel, red first on ties.
  logic [CH_W-1:0] r_q, g_q, b_q, hi_q, lo_q;
  sector_e         sec_q;
  sector_e         sec_d;
  logic [CH_W-1:0] hi_d, lo_d;

  always_comb begin
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      sec_d = SEC_RED;
      hi_d  = pix_i.red;
    end else if (pix_i.green >= pix_i.blue) begin
      sec_d = SEC_GREEN;
      hi_d  = pix_i.green;
    end else begin
      sec_d = SEC_BLUE;
      hi_d  = pix_i.blue;
    end
    lo_d = pix_i.red;
    if (pix_i.green < lo_d) lo_d = pix_i.green;
    if (pix_i.blue < lo_d) lo_d = pix_i.blue;
  end

  always_ff @(posedge clk_i) begin
    if (take[ST_CLS]) begin
      r_q   <= pix_i.red;
      g_q   <= pix_i.green;
      b_q   <= pix_i.blue;
      hi_q  <= hi_d;
      lo_q  <= lo_d;
      sec_q <= sec_d;
    end
  end

  // Prepare: range, sum, saturation divisor, hue numerator and six times the range.
  logic [CH_W-1:0]       dif;
  logic [SUM_W-1:0]      sum_c;
  logic [SUM_W-1:0]      den_full;
  logic [DVS_W-1:0]      dx;
  logic [DVS_W-1:0]      d6_d, n_d;
  logic [CH_W+OUT_W-1:0] x_d;

  always_comb begin
    dif      = hi_q - lo_q;
    sum_c    = {1'b0, hi_q} + {1'b0, lo_q};
    den_full = SUM_W'(2 * CH_MAX) - sum_c;
    dx       = {3'b000, dif};
    d6_d     = (dx << 2) + (dx << 1);
    case (sec_q)
      SEC_RED: begin
        if (g_q >= b_q) n_d = {3'b000, g_q - b_q};
        else            n_d = d6_d - {3'b000, b_q - g_q};
      end
      SEC_GREEN: n_d = (dx << 1) + {3'b000, b_q} - {3'b000, r_q};
      SEC_BLUE:  n_d = (dx << 2) + {3'b000, r_q} - {3'b000, g_q};
      default:   n_d = '0;
    endcase
    // Range times full scale (65535) as a shift and a subtract.
    x_d = {dif, {OUT_W{1'b0}}} - {{OUT_W{1'b0}}, dif};
  end

  logic [SUM_W-1:0]  sum1_q;
  logic              achr1_q;
  logic [CH_W-1:0]   den_q;
  logic [DVS_W-1:0]  d6_q, n_q;
  logic [CH_W-1:0]   xhi_q;
  logic [OUT_W-1:0]  xlo_q;

  always_ff @(posedge clk_i) begin
    if (take[ST_PREP]) begin
      sum1_q  <= sum_c;
      achr1_q <= (dif == '0);
      den_q   <= (sum_c > SUM_W'(CH_MAX)) ? den_full[CH_W-1:0] : sum_c[CH_W-1:0];
      d6_q    <= d6_d;
      n_q     <= n_d;
      xhi_q   <= x_d[CH_W+OUT_W-1:OUT_W];
      xlo_q   <= x_d[OUT_W-1:0];
    end
  end

  // Divide: hue = N * 65536 / 6d and saturation = d * 65535 / den.
  logic [DIV_STEPS-1:0] div_en;
  logic [OUT_W-1:0]     hue_quo, sat_quo;

  assign div_en = take[ST_DIV0 +: DIV_STEPS];

  rgbhsl_div u_hue_div (
    .clk_i (clk_i),
    .en_i  (div_en),
    .rem_i ({{(REM_W-DVS_W){1'b0}}, n_q}),
    .dvs_i (d6_q),
    .dvd_i ('0),
    .quo_o (hue_quo)
  );

  rgbhsl_div u_sat_div (
    .clk_i (clk_i),
    .en_i  (div_en),
    .rem_i ({{(REM_W-CH_W){1'b0}}, xhi_q}),
    .dvs_i ({{(DVS_W-CH_W){1'b0}}, den_q}),
    .dvd_i (xlo_q),
    .quo_o (sat_quo)
  );

  // Sum and achromatic flag ride alongside the divide stages.
  logic [SUM_W-1:0] sb_sum_q  [DIV_STEPS];
  logic             sb_achr_q [DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (take[ST_DIV0]) begin
      sb_sum_q[0]  <= sum1_q;
      sb_achr_q[0] <= achr1_q;
    end
    for (int j = 1; j < DIV_STEPS; j++) begin
      if (take[ST_DIV0 + j]) begin
        sb_sum_q[j]  <= sb_sum_q[j-1];
        sb_achr_q[j] <= sb_achr_q[j-1];
      end
    end
  end

  // Output: lightness is sum * 65535 / 510 = sum * 257 / 2 exactly.
  logic [OUT_W:0]   lsum;
  logic [OUT_W-1:0] hue_q, sat_q, light_q;

  assign lsum = {sb_sum_q[DIV_STEPS-1], {CH_W{1'b0}}}
              + {{CH_W{1'b0}}, sb_sum_q[DIV_STEPS-1]};

  always_ff @(posedge clk_i) begin
    if (take[ST_OUT]) begin
      hue_q   <= sb_achr_q[DIV_STEPS-1] ? '0 : hue_quo;
      sat_q   <= sb_achr_q[DIV_STEPS-1] ? '0 : sat_quo;
      light_q <= lsum[OUT_W:1];
    end
  end

  assign hsl_o.valid      = v_q[ST_OUT];
  assign hsl_o.hue        = hue_q;
  assign hsl_o.saturation = sat_q;
  assign hsl_o.lightness  = light_q;

  // A chromatic pixel always has non-zero saturation, so zero saturation means zero hue.
  a_achr_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsl_o.valid && hsl_o.saturation == '0) |-> (hsl_o.hue == '0))
    else $error("zero saturation with non-zero hue");

  // A stalled result is never dropped.
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsl_o.valid && !hsl_o.ready) |=> hsl_o.valid)
    else $error("stalled result lost");

  // An empty first stage must always take a new pixel.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[ST_CLS] |-> pix_i.ready)
    else $error("input stalled with empty first stage");

endmodule

// ----- tb/sv/rgb_to_hsl_converter_core_test.sv -----
// Self-checking testbench for the RGB to HSL converter core: directed and random pixels.
module rgb_to_hsl_converter_core_test;
  import rgbhsl_pkg::*;

  localparam int FRAC_ONE      = 65535;
  localparam int TURN          = 65536;
  localparam int RANDOM_PIXELS = 1100;
  localparam int CALM_PIXELS   = 150;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 200000;

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] saturation;
    logic [OUT_W-1:0] lightness;
  } hsl_t;

  // Holds the HSL values still owed by the core, in pixel order.
  class hsl_scoreboard;
    hsl_t pending_hsl[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Exact rational conversion, truncated toward zero.
    function hsl_t convert_pixel(chan_t r, chan_t g, chan_t b);
      int   hi;
      int   lo;
      int   sum;
      int   range;
      int   den;
      int   sector;
      hsl_t res;
      hi = int'(r);
      lo = int'(r);
      if (int'(g) > hi) hi = int'(g);
      if (int'(b) > hi) hi = int'(b);
      if (int'(g) < lo) lo = int'(g);
      if (int'(b) < lo) lo = int'(b);
      sum = hi + lo;
      res.lightness = OUT_W'((sum * FRAC_ONE) / (2 * CH_MAX));
      if (hi == lo) begin
        // Grey pixel: no hue and no saturation.
        res.hue        = '0;
        res.saturation = '0;
      end else begin
        range = hi - lo;
        den   = (sum > CH_MAX) ? (2 * CH_MAX - sum) : sum;
        res.saturation = OUT_W'((range * FRAC_ONE) / den);
        // Red wins ties, then green; the sector offset keeps the angle positive.
        if (hi == int'(r)) begin
          if (g < b) sector = 6 * range - (int'(b) - int'(g));
          else       sector = int'(g) - int'(b);
        end else if (hi == int'(g)) begin
          sector = 2 * range + int'(b) - int'(r);
        end else begin
          sector = 4 * range + int'(r) - int'(g);
        end
        res.hue = OUT_W'((sector * TURN) / (6 * range));
      end
      return res;
    endfunction

    function void note_pixel(chan_t r, chan_t g, chan_t b);
      pending_hsl.push_back(convert_pixel(r, g, b));
    endfunction

    function void check_result(hsl_t got);
      hsl_t want;
      if (pending_hsl.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got hue=%0d sat=%0d light=%0d",
                 $time, got.hue, got.saturation, got.lightness);
        mismatches++;
        return;
      end
      want = pending_hsl.pop_front();
      if (got.hue !== want.hue) begin
        $display("%0t: hue mismatch, expected %0d, got %0d", $time, want.hue, got.hue);
        mismatches++;
      end
      if (got.saturation !== want.saturation) begin
        $display("%0t: saturation mismatch, expected %0d, got %0d",
                 $time, want.saturation, got.saturation);
        mismatches++;
      end
      if (got.lightness !== want.lightness) begin
        $display("%0t: lightness mismatch, expected %0d, got %0d",
                 $time, want.lightness, got.lightness);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_hsl.size();
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  rgbhsl_pix_if  pix ();
  rgbhsl_hsl_if  hsl ();
  hsl_scoreboard board;

  int cycle_count = 0;
  int stall_left  = 0;
  int stall_odds  = 0;
  int gap_odds;
  bit calm;

  // Directed pixels, packed as red, green, blue.
  logic [3*CH_W-1:0] directed_pixels [$] = '{
    24'h000000, 24'hffffff, 24'h808080, 24'hff0000, 24'h00ff00, 24'h0000ff,
    24'hff0001, 24'hff0100, 24'hffff00, 24'hff00ff, 24'h00ffff, 24'hc8c864,
    24'h64c8c8, 24'h010000, 24'h000100, 24'h000001, 24'hfeffff, 24'hc83764,
    24'hc83864, 24'h807f7f, 24'h817f80, 24'h7f8080, 24'h0a1400, 24'h3050a0
  };

  rgb_to_hsl_converter_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .hsl_o  (hsl)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with a hard stop in case the core hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: check each accepted beat, then choose the next ready level.
  always @(posedge clk) begin
    if (hsl.valid && hsl.ready) begin
      board.check_result({hsl.hue, hsl.saturation, hsl.lightness});
    end
    if (cycle_count % 64 == 0) stall_odds = $urandom_range(0, 3);
    if (stall_left > 0) begin
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) < stall_odds) begin
      stall_left = $urandom_range(1, 12);
    end
    hsl.ready <= rst_n && (stall_left == 0);
  end

  // Presents one pixel beat and waits until the core takes it.
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk); while (!pix.ready);
    board.note_pixel(r, g, b);
  endtask

  // Occasionally drops valid for a burst of idle cycles between beats.
  task automatic pause_input();
    if (!calm && $urandom_range(0, 7) < gap_odds) begin
      pix.valid <= 1'b0;
      pix.red   <= chan_t'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Main stimulus.
  initial begin
    chan_t r;
    chan_t g;
    chan_t b;
    int    hi;
    int    lo;
    int    mid;
    int    s;
    int    base;

    board       = new();
    gap_odds    = 2;
    calm        = 1'b0;
    rst_n       <= 1'b0;
    pix.valid   <= 1'b0;
    pix.red     <= '0;
    pix.green   <= '0;
    pix.blue    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes, every sector, ties and the saturation denominator switch.
    foreach (directed_pixels[i]) begin
      {r, g, b} = directed_pixels[i];
      send_pixel(r, g, b);
      pause_input();
    end

    // Random pixels, weighted towards greys, ties and the half-lightness boundary.
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      if (n % 64 == 0) gap_odds = $urandom_range(0, 4);
      if (n >= RANDOM_PIXELS - CALM_PIXELS) calm = 1'b1;
      hi  = 0;
      lo  = 0;
      mid = 0;
      case ($urandom_range(0, 9))
        5: begin
          r = chan_t'($urandom);
          g = r;
          b = r;
        end
        6: begin
          hi  = $urandom_range(1, 255);
          lo  = $urandom_range(0, hi - 1);
          mid = hi;
        end
        7: begin
          base = $urandom_range(2, 253);
          r = chan_t'(base + int'($urandom_range(0, 4)) - 2);
          g = chan_t'(base + int'($urandom_range(0, 4)) - 2);
          b = chan_t'(base + int'($urandom_range(0, 4)) - 2);
        end
        8: begin
          r = ($urandom_range(0, 2) == 0) ? chan_t'($urandom) :
              ($urandom_range(0, 1) ? 8'hff : 8'h00);
          g = ($urandom_range(0, 2) == 0) ? chan_t'($urandom) :
              ($urandom_range(0, 1) ? 8'hff : 8'h00);
          b = ($urandom_range(0, 2) == 0) ? chan_t'($urandom) :
              ($urandom_range(0, 1) ? 8'hff : 8'h00);
        end
        9: begin
          s   = $urandom_range(254, 256);
          hi  = $urandom_range((s + 1) / 2, (s > CH_MAX) ? CH_MAX : s);
          lo  = s - hi;
          mid = $urandom_range(lo, hi);
        end
        default: begin
          r = chan_t'($urandom);
          g = chan_t'($urandom);
          b = chan_t'($urandom);
        end
      endcase
      // Ordered channel sets are spread over a random permutation.
      if (hi != 0) begin
        case ($urandom_range(0, 5))
          0:       {r, g, b} = {chan_t'(hi), chan_t'(mid), chan_t'(lo)};
          1:       {r, g, b} = {chan_t'(hi), chan_t'(lo), chan_t'(mid)};
          2:       {r, g, b} = {chan_t'(mid), chan_t'(hi), chan_t'(lo)};
          3:       {r, g, b} = {chan_t'(lo), chan_t'(hi), chan_t'(mid)};
          4:       {r, g, b} = {chan_t'(mid), chan_t'(lo), chan_t'(hi)};
          default: {r, g, b} = {chan_t'(lo), chan_t'(mid), chan_t'(hi)};
        endcase
      end
      send_pixel(r, g, b);
      pause_input();
    end
    pix.valid <= 1'b0;

    // Drain the pipeline, then give any stray beat time to show up.
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
